/* design/ewek_pkg.sv */
package ewek_pkg;

    localparam int POS_W       = 32;
    localparam int DELTA_W     = 32;
    localparam int VEL_W       = 16;
    localparam int EC_W        = 8;
    localparam int STR_W       = 16;
    localparam int KS_W        = 8;
    localparam int STEP_W      = 9;

    localparam int IN_TDATA_W  = 56;   // position, velocity_in, key_a_in, key_b_in
    localparam int OUT_TDATA_W = 24;   // velocity_out, key_a_out, key_b_out, echo_active
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    // shared multiplier operands and the product / dividend register
    localparam int MUL_A_W     = 48;
    localparam int MUL_B_W     = 16;
    localparam int PROD_W      = 56;
    localparam int DIV_ITER    = PROD_W / 2;          // two quotient bits per cycle
    localparam int DIV_CNT_W   = $clog2(DIV_ITER);
    localparam int FRAC_W      = 8;                   // Q8.8 strength
    localparam int KPROD_W     = DELTA_W + KS_W;      // |diff| * key_strength
    localparam int ACC_W       = KPROD_W + 2;

    localparam logic [STEP_W-1:0] STEP_IDLE        = '1;
    localparam logic [EC_W-1:0]   ECHO_COUNT_RST   = EC_W'(8);
    localparam logic [STR_W-1:0]  STRENGTH_RST     = STR_W'(256);   // 1.0 in Q8.8
    localparam logic [KS_W-1:0]   KEY_STRENGTH_RST = KS_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE         = 8'd0,
        REG_ECHO_COUNT   = 8'd1,
        REG_STRENGTH     = 8'd2,
        REG_KEY_STRENGTH = 8'd3
    } t_cfg_reg;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_MUL1 = 9'b000000100,
        S_MUL2 = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_FADE = 9'b000100000,
        S_KMUL = 9'b001000000,
        S_KACC = 9'b010000000,
        S_KEY  = 9'b100000000
    } t_state;

endpackage

/* design/encoder_wheel_echo_and_key_pulse.sv */
// Channel   Dir  Handshake                     Payload (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready   position, velocity_in, key_a_in, key_b_in
// m_axis    out  m_axis_tvalid/m_axis_tready   velocity_out, key_a_out, key_b_out, echo_active
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One request at a time. A wheel tick with an active fade passes decode, two passes
// through the shared multiplier, the radix-4 divider by echo_count and a scale and
// saturate step. Other wheel ticks end at decode; key ticks pass decode, multiply,
// accumulate and key output (decode and key output when the position did not move).
// s_axis_tready is high only while the sequencer is idle and no result waits.
// Reset (synchronous, active low) restores the configuration, sequencer and echo state.
module encoder_wheel_echo_and_key_pulse
    import ewek_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] position, [47:32] velocity_in, [48] key_a_in, [49] key_b_in
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [15:0] velocity_out, [16] key_a_out, [17] key_b_out, [18] echo_active
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sd2147483648);
    localparam logic signed [VEL_W+2:0] VSUM_MAX = (VEL_W+3)'(32767);
    localparam logic signed [VEL_W+2:0] VSUM_MIN = (VEL_W+3)'(-32768);

    t_state r_state;

    // configuration
    logic              r_mode;
    logic [EC_W-1:0]   r_ec;
    logic [STR_W-1:0]  r_str;
    logic [KS_W-1:0]   r_ks;

    // persistent state
    logic [POS_W-1:0]         r_last;
    logic signed [DELTA_W-1:0] r_pending;
    logic [STEP_W-1:0]        r_step;

    // captured request
    logic [POS_W-1:0]         r_pos;
    logic signed [VEL_W-1:0]  r_vel;
    logic                     r_ka;
    logic                     r_kb;

    // working registers
    logic [PROD_W-1:0]        r_prod;
    logic [EC_W-1:0]          r_rem;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic [DELTA_W-1:0]       r_kmag;
    logic                     r_kneg;

    // result register
    logic                     r_ovalid;
    logic [VEL_W-1:0]         r_vel_o;
    logic                     r_ka_o;
    logic                     r_kb_o;
    logic                     r_act_o;

    logic                     w_in_acc;
    logic [POS_W-1:0]         w_diff;
    logic signed [DELTA_W-1:0] w_diff_s;
    logic                     w_moved;
    logic [STEP_W-1:0]        w_step_eff;
    logic [DELTA_W-1:0]       w_pmag;
    logic [MUL_A_W-1:0]       w_mul_a;
    logic [MUL_B_W-1:0]       w_mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] w_mul;
    logic [EC_W:0]            w_t1;
    logic [EC_W:0]            w_t2;
    logic                     w_q1;
    logic                     w_q2;
    logic [EC_W-1:0]          w_rem1;
    logic [EC_W-1:0]          w_rem2;
    logic [PROD_W-FRAC_W-1:0] w_q;
    logic [VEL_W:0]           w_qc;
    logic signed [VEL_W+2:0]  w_contrib;
    logic signed [VEL_W+2:0]  w_vsum;
    logic [VEL_W-1:0]         w_vsat;
    logic signed [ACC_W-1:0]  w_kterm;
    logic signed [ACC_W-1:0]  w_acc;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'b0, r_act_o, r_kb_o, r_ka_o, r_vel_o};

    // position difference, read as a signed number of the position width
    assign w_diff     = r_pos - r_last;
    assign w_diff_s   = DELTA_W'(signed'(w_diff));
    assign w_moved    = (w_diff != '0);
    assign w_step_eff = w_moved ? '0 : r_step;
    assign w_pmag     = r_pending[DELTA_W-1] ? DELTA_W'(-r_pending) : DELTA_W'(r_pending);

    // shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MUL1: begin
                w_mul_a = MUL_A_W'(w_pmag);
                w_mul_b = r_str;
            end
            S_MUL2: begin
                w_mul_a = r_prod[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_ec - r_step[EC_W-1:0]);
            end
            S_KMUL: begin
                w_mul_a = MUL_A_W'(r_kmag);
                w_mul_b = MUL_B_W'(r_ks);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // radix-4 restoring divide by echo_count, quotient shifts into r_prod
    always_comb begin
        w_t1   = {r_rem, r_prod[PROD_W-1]};
        w_q1   = (w_t1 >= {1'b0, r_ec});
        w_rem1 = w_q1 ? EC_W'(w_t1 - {1'b0, r_ec}) : w_t1[EC_W-1:0];
        w_t2   = {w_rem1, r_prod[PROD_W-2]};
        w_q2   = (w_t2 >= {1'b0, r_ec});
        w_rem2 = w_q2 ? EC_W'(w_t2 - {1'b0, r_ec}) : w_t2[EC_W-1:0];
    end

    // drop the Q8.8 fraction, clamp (anything past 2^16 saturates anyway)
    always_comb begin
        w_q  = r_prod[PROD_W-1:FRAC_W];
        w_qc = (|w_q[PROD_W-FRAC_W-1:VEL_W]) ? (VEL_W+1)'(1 << VEL_W)
                                              : {1'b0, w_q[VEL_W-1:0]};
        w_contrib = r_pending[DELTA_W-1] ? -(VEL_W+3)'(w_qc) : (VEL_W+3)'(w_qc);
        w_vsum    = (VEL_W+3)'(r_vel) + w_contrib;
        if (w_vsum > VSUM_MAX) begin
            w_vsat = VSUM_MAX[VEL_W-1:0];
        end else if (w_vsum < VSUM_MIN) begin
            w_vsat = VSUM_MIN[VEL_W-1:0];
        end else begin
            w_vsat = w_vsum[VEL_W-1:0];
        end
    end

    // key accumulator add
    always_comb begin
        w_kterm = r_kneg ? -ACC_W'(r_prod[KPROD_W-1:0]) : ACC_W'(r_prod[KPROD_W-1:0]);
        w_acc   = ACC_W'(r_pending) + w_kterm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_ec     <= ECHO_COUNT_RST;
            r_str    <= STRENGTH_RST;
            r_ks     <= KEY_STRENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MODE:         r_mode <= i_cfg_data[0];
                REG_ECHO_COUNT:   r_ec   <= i_cfg_data[EC_W-1:0];
                REG_STRENGTH:     r_str  <= i_cfg_data[STR_W-1:0];
                REG_KEY_STRENGTH: r_ks   <= i_cfg_data[KS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_last    <= '0;
            r_pending <= '0;
            r_step    <= STEP_IDLE;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_pos   <= s_axis_tdata[POS_W-1:0];
                        r_vel   <= s_axis_tdata[47:32];
                        r_ka    <= s_axis_tdata[48];
                        r_kb    <= s_axis_tdata[49];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (!r_mode) begin
                        if (w_moved) begin
                            r_pending <= w_diff_s;
                            r_last    <= r_pos;
                            r_step    <= '0;
                        end
                        if (w_step_eff < STEP_W'(r_ec)) begin
                            r_state <= S_MUL1;
                        end else begin
                            r_vel_o  <= r_vel;
                            r_ka_o   <= r_ka;
                            r_kb_o   <= r_kb;
                            r_act_o  <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_kneg <= w_diff_s[DELTA_W-1];
                        r_kmag <= w_diff_s[DELTA_W-1] ? DELTA_W'(-w_diff_s)
                                                      : DELTA_W'(w_diff_s);
                        if (w_moved) begin
                            r_last  <= r_pos;
                            r_state <= S_KMUL;
                        end else begin
                            r_state <= S_KEY;
                        end
                    end
                end
                S_MUL1: begin
                    r_prod  <= PROD_W'(w_mul);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_prod  <= PROD_W'(w_mul);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_prod <= {r_prod[PROD_W-3:0], w_q1, w_q2};
                    r_rem  <= w_rem2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                        r_state <= S_FADE;
                    end
                end
                S_FADE: begin
                    r_vel_o  <= w_vsat;
                    r_ka_o   <= r_ka;
                    r_kb_o   <= r_kb;
                    r_act_o  <= 1'b1;
                    r_step   <= r_step + 1'b1;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_KMUL: begin
                    r_prod  <= PROD_W'(w_mul);
                    r_state <= S_KACC;
                end
                S_KACC: begin
                    if (w_acc > ACC_MAX) begin
                        r_pending <= ACC_MAX[DELTA_W-1:0];
                    end else if (w_acc < ACC_MIN) begin
                        r_pending <= ACC_MIN[DELTA_W-1:0];
                    end else begin
                        r_pending <= w_acc[DELTA_W-1:0];
                    end
                    r_state <= S_KEY;
                end
                S_KEY: begin
                    r_vel_o <= r_vel;
                    r_act_o <= 1'b0;
                    if (r_pending > 0) begin
                        r_ka_o    <= 1'b1;
                        r_kb_o    <= r_kb;
                        r_pending <= r_pending - 1'b1;
                    end else if (r_pending < 0) begin
                        r_ka_o    <= r_ka;
                        r_kb_o    <= 1'b1;
                        r_pending <= r_pending + 1'b1;
                    end else begin
                        r_ka_o <= 1'b0;
                        r_kb_o <= 1'b0;
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/ewek_checker.sv */
module ewek_checker
    import ewek_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // one request in flight: never ready for input while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request accepted without a busy cycle");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind encoder_wheel_echo_and_key_pulse ewek_checker u_ewek_checker (.*);
